/* rtl/urs_pkg.sv */
// Shared types, constants and the checksum span helper for the UDP rate signal rewriter.
package urs_pkg;

	localparam int unsigned POS_W   = 11;
	localparam int unsigned SPAN_W  = 14;
	localparam int unsigned PADDR_W = 2;
	localparam int unsigned RATE_W  = 7;

	localparam logic [POS_W-1:0]   POS_SAT   = 11'd2047;
	localparam logic [POS_W-1:0]   UDP_BASE  = 11'd34;
	localparam logic [POS_W-1:0]   MIN_LAST  = 11'd46;
	localparam logic [15:0]        ETH_IPV4  = 16'h0800;
	localparam logic [7:0]         PROTO_UDP = 8'd17;
	localparam logic [31:0]        SIG_VERSION = 32'h6f7dc0fd;

	localparam logic [PADDR_W-1:0] ADDR_TARGET_RATE = 2'd0;

	// Frame summary handed from the byte tracker to the result stage.
	typedef struct packed {
		logic        len_ok;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [7:0]  signal_byte;
		logic [31:0] version_word;
		logic [31:0] running_sum;
	} frame_sum_t;

	// Contribution of one byte at frame position pos to the UDP span sum.
	function automatic logic [15:0] span_term(input logic [POS_W-1:0] pos,
			input logic [7:0] b, input logic [SPAN_W-1:0] span);
		logic [SPAN_W-1:0] r;
		logic [15:0]       t;
		r = SPAN_W'(pos) - SPAN_W'(UDP_BASE);
		t = '0;
		if (pos >= UDP_BASE) begin
			if (r < span)
				t = r[0] ? {8'h00, b} : {b, 8'h00};
			else if (r == span)
				t = {b, 8'h00};
		end
		return t;
	endfunction

endpackage

/* rtl/urs_if.sv */
// Request channel interfaces: frame bytes in, patch results out.
interface urs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface urs_out_if;
	logic        valid;
	logic        ready;
	logic        modified;
	logic [7:0]  new_signal_byte;
	logic [31:0] new_version_word;
	logic [15:0] new_udp_checksum;

	modport source(output valid, modified, new_signal_byte, new_version_word,
		new_udp_checksum, input ready);
	modport sink(input valid, modified, new_signal_byte, new_version_word,
		new_udp_checksum, output ready);
endinterface

/* rtl/udp_rate_signal_rewriter_core.sv */
// Top level of the UDP rate signal rewriter.
//
//  channel  dir  width  meaning
//  in_ch    in   8+1    frame byte and last-byte marker, one request per byte
//  out_ch   out  1+56   patch values for bytes 40..46 and modified flag, one per frame
//  apb      in   32     target_rate at byte address 0
//
// One byte is accepted every cycle while input ready is high; the result for a frame
// goes through the frame summary register, then the result register, after its last
// byte is accepted. The frame tracker does one capture, one 17-bit add and one 32-bit
// accumulate per byte; the result stage does the qualification, a short add chain and
// the end-around fold. Reset clears the tracker state, the valid flags and the target
// rate at once; no clearing pass. A stalled result holds its register; input ready
// drops only when a finished frame summary is also waiting behind it.
module udp_rate_signal_rewriter_core #(
	parameter int MAX_SUM_BYTES = 1480
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [urs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	urs_in_if.sink                      in_ch,
	urs_out_if.source                   out_ch
);

	localparam int SPAN_BYTES = ((MAX_SUM_BYTES + 1) / 2) * 2;
	localparam logic [urs_pkg::SPAN_W-1:0] SPAN = urs_pkg::SPAN_W'(SPAN_BYTES);

	logic [urs_pkg::RATE_W-1:0] target_rate;
	urs_pkg::frame_sum_t        fsum;
	logic                       fsum_valid;
	logic                       fsum_ready;

	urs_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.target_rate (target_rate)
	);

	urs_frame_track #(
		.SPAN (SPAN)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.fsum       (fsum),
		.fsum_valid (fsum_valid),
		.fsum_ready (fsum_ready)
	);

	urs_result #(
		.SPAN (SPAN)
	) u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.fsum        (fsum),
		.fsum_valid  (fsum_valid),
		.fsum_ready  (fsum_ready),
		.target_rate (target_rate),
		.out_ch      (out_ch)
	);

endmodule

/* rtl/urs_cfg_regs.sv */
// APB-style configuration register holding the target rate.
module urs_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [urs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [urs_pkg::RATE_W-1:0]  target_rate
);

	logic [urs_pkg::RATE_W-1:0] target_rate_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == urs_pkg::ADDR_TARGET_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_rate_q <= '0;
		end else if (wr_en) begin
			target_rate_q <= pwdata[urs_pkg::RATE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == urs_pkg::ADDR_TARGET_RATE)
			prdata = 32'(target_rate_q);
	end

	assign target_rate = target_rate_q;

endmodule

/* rtl/urs_frame_track.sv */
// Per-byte frame tracker: captures header fields and accumulates the checksum sum.
module urs_frame_track #(
	parameter logic [urs_pkg::SPAN_W-1:0] SPAN = 14'd1480
) (
	input  logic                clk,
	input  logic                arst_n,
	urs_in_if.sink              in_ch,
	output urs_pkg::frame_sum_t fsum,
	output logic                fsum_valid,
	input  logic                fsum_ready
);

	logic [urs_pkg::POS_W-1:0] pos_q;
	logic [15:0]               ether_q;
	logic [7:0]                proto_q;
	logic [7:0]                sig_q;
	logic [31:0]               ver_q;
	logic [31:0]               sum_q;

	logic [urs_pkg::POS_W-1:0] pos_nx;
	logic [15:0]               ether_nx;
	logic [7:0]                proto_nx;
	logic [7:0]                sig_nx;
	logic [31:0]               ver_nx;
	logic [31:0]               sum_nx;
	logic [15:0]               pseudo_t;
	logic [15:0]               span_t;
	logic                      active;
	logic                      acc;
	logic [7:0]                b;

	urs_pkg::frame_sum_t fsum_s1;
	logic                fsum_valid_s1;

	assign b      = in_ch.data_byte;
	assign active = (pos_q != urs_pkg::POS_SAT);
	assign in_ch.ready = !fsum_valid_s1 || fsum_ready;
	assign acc    = in_ch.valid && in_ch.ready;

	always_comb begin
		pos_nx   = pos_q;
		ether_nx = ether_q;
		proto_nx = proto_q;
		sig_nx   = sig_q;
		ver_nx   = ver_q;
		pseudo_t = '0;
		span_t   = '0;
		if (active) begin
			if (pos_q == 11'd12 || pos_q == 11'd13)
				ether_nx = {ether_q[7:0], b};
			if (pos_q == 11'd23)
				proto_nx = b;
			if ((pos_q >= 11'd26 && pos_q <= 11'd33) || pos_q == 11'd38 || pos_q == 11'd39)
				pseudo_t = pos_q[0] ? {8'h00, b} : {b, 8'h00};
			if (pos_q == 11'd42)
				sig_nx = b;
			if (pos_q >= 11'd43 && pos_q <= 11'd46)
				ver_nx = {ver_q[23:0], b};
			// skip the checksum, signal and version fields; the result stage adds the new values
			if (pos_q < 11'd40 || pos_q > 11'd46)
				span_t = urs_pkg::span_term(pos_q, b, SPAN);
			pos_nx = pos_q + 11'd1;
		end
		sum_nx = sum_q + 32'({1'b0, pseudo_t} + {1'b0, span_t});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			ether_q       <= '0;
			proto_q       <= '0;
			sig_q         <= '0;
			ver_q         <= '0;
			sum_q         <= '0;
			fsum_valid_s1 <= 1'b0;
		end else begin
			if (fsum_valid_s1 && fsum_ready)
				fsum_valid_s1 <= 1'b0;
			if (acc) begin
				if (in_ch.last_byte) begin
					pos_q         <= '0;
					ether_q       <= '0;
					proto_q       <= '0;
					sig_q         <= '0;
					ver_q         <= '0;
					sum_q         <= '0;
					fsum_valid_s1 <= 1'b1;
				end else begin
					pos_q   <= pos_nx;
					ether_q <= ether_nx;
					proto_q <= proto_nx;
					sig_q   <= sig_nx;
					ver_q   <= ver_nx;
					sum_q   <= sum_nx;
				end
			end
		end
	end

	// summary payload: loaded on the last byte only
	always_ff @(posedge clk) begin
		if (acc && in_ch.last_byte) begin
			fsum_s1.len_ok       <= (pos_q >= urs_pkg::MIN_LAST);
			fsum_s1.ether_type   <= ether_nx;
			fsum_s1.ip_protocol  <= proto_nx;
			fsum_s1.signal_byte  <= sig_nx;
			fsum_s1.version_word <= ver_nx;
			fsum_s1.running_sum  <= sum_nx;
		end
	end

	assign fsum       = fsum_s1;
	assign fsum_valid = fsum_valid_s1;

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.last_byte |=> pos_q == '0)
		else $error("byte position not cleared after last byte");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_ch.last_byte && active |=> pos_q == $past(pos_q) + 11'd1)
		else $error("byte position did not advance");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fsum_valid_s1 && !fsum_ready |=> fsum_valid_s1 && $stable(fsum_s1))
		else $error("frame summary lost while stalled");

endmodule

/* rtl/urs_result.sv */
// Qualification, field rewrite and checksum fold; holds the result register.
module urs_result #(
	parameter logic [urs_pkg::SPAN_W-1:0] SPAN = 14'd1480
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  urs_pkg::frame_sum_t        fsum,
	input  logic                       fsum_valid,
	output logic                       fsum_ready,
	input  logic [urs_pkg::RATE_W-1:0] target_rate,
	urs_out_if.source                  out_ch
);

	logic        out_valid_q;
	logic        modified_q;
	logic [7:0]  nsb_q;
	logic [31:0] nver_q;
	logic [15:0] ck_q;

	logic                       qual;
	logic                       rewrite;
	logic [urs_pkg::RATE_W-1:0] rate;
	logic [7:0]                 nsb;
	logic [31:0]                nver;
	logic [31:0]                s;
	logic [16:0]                f1;
	logic [15:0]                f2;
	logic                       load;

	assign fsum_ready = !out_valid_q || out_ch.ready;
	assign load       = fsum_valid && fsum_ready;

	always_comb begin
		qual = fsum.len_ok
			&& fsum.ether_type == urs_pkg::ETH_IPV4
			&& fsum.ip_protocol == urs_pkg::PROTO_UDP
			&& fsum.signal_byte[7]
			&& fsum.version_word[30:0] == urs_pkg::SIG_VERSION[30:0];
		rate    = {fsum.signal_byte[5:0], fsum.version_word[31]};
		rewrite = qual && (rate >= target_rate);
		nsb     = {fsum.signal_byte[7:6], target_rate[6:1]};
		nver    = {target_rate[0], urs_pkg::SIG_VERSION[30:0]};
		s = fsum.running_sum + 32'(fsum.ip_protocol)
			+ 32'(urs_pkg::span_term(11'd42, nsb, SPAN))
			+ 32'(urs_pkg::span_term(11'd43, nver[31:24], SPAN))
			+ 32'(urs_pkg::span_term(11'd44, nver[23:16], SPAN))
			+ 32'(urs_pkg::span_term(11'd45, nver[15:8], SPAN))
			+ 32'(urs_pkg::span_term(11'd46, nver[7:0], SPAN));
		f1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		f2 = f1[15:0] + {15'd0, f1[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			modified_q <= rewrite;
			nsb_q      <= rewrite ? nsb : 8'd0;
			nver_q     <= rewrite ? nver : 32'd0;
			ck_q       <= rewrite ? ~f2 : 16'd0;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.modified         = modified_q;
	assign out_ch.new_signal_byte  = nsb_q;
	assign out_ch.new_version_word = nver_q;
	assign out_ch.new_udp_checksum = ck_q;

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !modified_q |-> nsb_q == 8'd0 && nver_q == 32'd0 && ck_q == 16'd0)
		else $error("unmodified result carries nonzero fields");

	a_version: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && modified_q |-> nver_q[30:0] == urs_pkg::SIG_VERSION[30:0])
		else $error("rewritten version word lost its constant bits");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("frame summary taken but no result presented");

endmodule

/* test/udp_rate_signal_rewriter_core_tb.sv */
// Self-checking testbench for the UDP rate signal rewriter core.
module udp_rate_signal_rewriter_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SUM_BYTES = 1480;
	localparam int SPAN_BYTES    = ((MAX_SUM_BYTES + 1) / 2) * 2;
	localparam int OFF_ETYPE     = 12;
	localparam int OFF_PROTO     = 23;
	localparam int OFF_SRC_IP    = 26;
	localparam int OFF_UDP_LEN   = 38;
	localparam int OFF_CSUM      = 40;
	localparam int OFF_SIG       = 42;
	localparam int OFF_VER       = 43;
	localparam int HDR_BYTES     = 47;
	localparam int RAND_BYTES    = 1000;
	localparam int RAND_FRAMES   = 16;
	localparam int DRAIN_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum int {FLAW_NONE, FLAW_NOISE, FLAW_ETYPE, FLAW_PROTO, FLAW_MARK,
		FLAW_VERSION} flaw_t;

	typedef struct packed {
		logic [10:0] pos;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [7:0]  sig;
		logic [31:0] ver;
		logic [31:0] sum;
	} frame_track_t;

	typedef struct packed {
		logic        modified;
		logic [7:0]  sig;
		logic [31:0] ver;
		logic [15:0] csum;
	} patch_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} wire_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [urs_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	urs_in_if  in_ch();
	urs_out_if out_ch();

	udp_rate_signal_rewriter_core #(.MAX_SUM_BYTES(MAX_SUM_BYTES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	wire_byte_t   byte_q[$];
	patch_t       patch_q[$];
	frame_track_t trk;
	patch_t       acc_patch, got_patch, want_patch;
	logic [6:0]   tgt_rate;
	bit           in_taken;
	bit           steady;
	int           errors, cycles, n_bytes, n_rewritten, n_plain, n_settings;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sum contribution of a byte to the UDP part of the checksum.
	function automatic logic [31:0] udp_term(input int unsigned p, input logic [7:0] b);
		int unsigned r;
		if (p < urs_pkg::UDP_BASE)
			return 32'd0;
		r = p - urs_pkg::UDP_BASE;
		if (r < SPAN_BYTES)
			return (r % 2) ? {24'd0, b} : {16'd0, b, 8'd0};
		if (r == SPAN_BYTES)
			return {16'd0, b, 8'd0};
		return 32'd0;
	endfunction

	// Advance the frame tracker by one byte; returns 1 when a patch request is due.
	function automatic bit track_byte(inout frame_track_t st, input logic [7:0] b,
			input logic last, input logic [6:0] rate, output patch_t res);
		int unsigned p;
		bit          took, ok;
		logic [6:0]  adv;
		logic [31:0] s;
		res = '0;
		p = st.pos;
		took = (p < urs_pkg::POS_SAT);
		if (took) begin
			if (p == OFF_ETYPE || p == OFF_ETYPE + 1)
				st.etype = {st.etype[7:0], b};
			if (p == OFF_PROTO)
				st.proto = b;
			if ((p >= OFF_SRC_IP && p < OFF_SRC_IP + 8) || p == OFF_UDP_LEN
					|| p == OFF_UDP_LEN + 1)
				st.sum += (p % 2) ? {24'd0, b} : {16'd0, b, 8'd0};
			if (p == OFF_SIG)
				st.sig = b;
			if (p >= OFF_VER && p < OFF_VER + 4)
				st.ver = {st.ver[23:0], b};
			// checksum field and rewritten bytes are summed with their new values
			if (p < OFF_CSUM || p > OFF_VER + 3)
				st.sum += udp_term(p, b);
			st.pos = st.pos + 11'd1;
		end
		if (!last)
			return 1'b0;
		ok = took ? (p >= urs_pkg::MIN_LAST) : (st.pos > urs_pkg::MIN_LAST);
		ok = ok && st.etype == urs_pkg::ETH_IPV4 && st.proto == urs_pkg::PROTO_UDP
			&& st.sig[7] && st.ver[30:0] == urs_pkg::SIG_VERSION[30:0];
		adv = {st.sig[5:0], st.ver[31]};
		if (ok && adv >= rate) begin
			res.modified = 1'b1;
			res.sig = {st.sig[7:6], rate[6:1]};
			res.ver = {rate[0], urs_pkg::SIG_VERSION[30:0]};
			s = st.sum + st.proto + udp_term(OFF_SIG, res.sig)
				+ udp_term(OFF_VER, res.ver[31:24]) + udp_term(OFF_VER + 1, res.ver[23:16])
				+ udp_term(OFF_VER + 2, res.ver[15:8]) + udp_term(OFF_VER + 3, res.ver[7:0]);
			s = s[15:0] + s[31:16];
			s = s[15:0] + s[31:16];
			res.csum = ~s[15:0];
		end
		st = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	// Build one frame and queue its bytes. Good frames carry the given rate.
	task automatic queue_frame(input int len, input flaw_t flaw, input logic [6:0] rate,
			input bit zero_sum = 1'b0);
		logic [7:0]   f[];
		int           k, idx;
		frame_track_t t;
		patch_t       pr;
		wire_byte_t   wb;
		f = new[(len > HDR_BYTES) ? len : HDR_BYTES];
		foreach (f[i])
			f[i] = 8'($urandom);
		if (flaw != FLAW_NOISE) begin
			{f[OFF_ETYPE], f[OFF_ETYPE + 1]} = urs_pkg::ETH_IPV4;
			f[OFF_PROTO] = urs_pkg::PROTO_UDP;
			f[OFF_SIG] = {1'b1, f[OFF_SIG][6], rate[6:1]};
			{f[OFF_VER], f[OFF_VER + 1], f[OFF_VER + 2], f[OFF_VER + 3]} =
				{rate[0], urs_pkg::SIG_VERSION[30:0]};
		end
		case (flaw)
			FLAW_ETYPE: f[OFF_ETYPE + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
			FLAW_PROTO: f[OFF_PROTO] ^= 8'($urandom_range(255, 1));
			FLAW_MARK: f[OFF_SIG][7] = 1'b0;
			FLAW_VERSION: begin
				k = $urandom_range(30);
				idx = OFF_VER + 3 - k / 8;
				f[idx][k % 8] = ~f[idx][k % 8];
			end
			default: ;
		endcase
		// pick the word at 47..48 so the folded sum comes out all ones
		if (zero_sum) begin
			f[47] = 8'h00;
			f[48] = 8'h00;
			t = '0;
			for (int i = 0; i < len; i++)
				void'(track_byte(t, f[i], i == len - 1, tgt_rate, pr));
			{f[48], f[47]} = pr.csum;
		end
		for (int i = 0; i < len; i++) begin
			wb.b = f[i];
			wb.last = (i == len - 1);
			byte_q.push_back(wb);
		end
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (byte_q.size() != 0 || patch_q.size() != 0 || in_ch.valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= urs_pkg::ADDR_TARGET_RATE;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_target_rate(input logic [6:0] v);
		logic [31:0] rd;
		drain();
		apb_access(1'b1, {25'd0, v}, rd);
		tgt_rate = v;
		apb_access(1'b0, 32'd0, rd);
		if (rd !== {25'd0, v})
			report_mismatch("target_rate readback", rd, {25'd0, v});
		n_settings++;
	endtask

	// Input side: hold a request until taken, then advance or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= byte_q[0].b;
				in_ch.last_byte <= byte_q[0].last;
				void'(byte_q.pop_front());
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= arst_n && (steady || $urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			n_bytes++;
			if (track_byte(trk, in_ch.data_byte, in_ch.last_byte, tgt_rate, acc_patch))
				patch_q.push_back(acc_patch);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got_patch = {out_ch.modified, out_ch.new_signal_byte, out_ch.new_version_word,
				out_ch.new_udp_checksum};
			if (patch_q.size() == 0) begin
				report_mismatch("result with no frame pending", 32'(got_patch.modified), 32'd0);
			end else begin
				want_patch = patch_q.pop_front();
				if (got_patch.modified !== want_patch.modified)
					report_mismatch("modified", 32'(got_patch.modified),
						32'(want_patch.modified));
				if (got_patch.sig !== want_patch.sig)
					report_mismatch("new_signal_byte", 32'(got_patch.sig), 32'(want_patch.sig));
				if (got_patch.ver !== want_patch.ver)
					report_mismatch("new_version_word", got_patch.ver, want_patch.ver);
				if (got_patch.csum !== want_patch.csum)
					report_mismatch("new_udp_checksum", 32'(got_patch.csum),
						32'(want_patch.csum));
				if (want_patch.modified)
					n_rewritten++;
				else
					n_plain++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out with %0d bytes queued, %0d results pending",
				byte_q.size(), patch_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int         len, rand_bytes, rand_frames, ph, pick;
		flaw_t      flaw;
		logic [6:0] rate;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		trk = '0;
		tgt_rate = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at the lowest target: every qualifying frame is rewritten
		set_target_rate(7'd0);
		queue_frame(1, FLAW_NONE, 7'd0);
		queue_frame(HDR_BYTES, FLAW_NONE, 7'($urandom));
		queue_frame(HDR_BYTES - 1, FLAW_NONE, 7'($urandom));
		queue_frame(HDR_BYTES + 1, FLAW_NONE, 7'd127);
		queue_frame(60, FLAW_NOISE, 7'd0);
		queue_frame(60, FLAW_ETYPE, 7'd5);
		queue_frame(60, FLAW_PROTO, 7'd5);
		queue_frame(60, FLAW_MARK, 7'd5);
		queue_frame(60, FLAW_VERSION, 7'd5);
		queue_frame(50, FLAW_NONE, 7'($urandom), 1'b1);

		// highest target: only the top rate gets rewritten
		set_target_rate(7'd127);
		queue_frame(HDR_BYTES, FLAW_NONE, 7'd127);
		queue_frame(HDR_BYTES, FLAW_NONE, 7'd126);
		queue_frame(64, FLAW_NONE, 7'd0);
		queue_frame(71, FLAW_NONE, 7'd127);

		rand_bytes = 0;
		rand_frames = 0;
		for (ph = 0; rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES; ph++) begin
			case (ph % 4)
				0: rate = 7'd1;
				1: rate = 7'd64;
				2: rate = 7'd126;
				default: rate = 7'($urandom);
			endcase
			set_target_rate(rate);
			steady = (ph == 1);
			for (int n = 0; n < 8; n++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					flaw = FLAW_NONE;
				else if (pick < 80)
					flaw = FLAW_NOISE;
				else
					flaw = flaw_t'(FLAW_ETYPE + $urandom_range(3));
				pick = $urandom_range(99);
				if (pick < 8)
					len = $urandom_range(HDR_BYTES - 1, 1);
				else if (pick < 93)
					len = $urandom_range(90, HDR_BYTES);
				else
					len = $urandom_range(300, 91);
				case ($urandom_range(3))
					0: rate = tgt_rate;
					1: rate = 7'($urandom);
					2: rate = (tgt_rate != 7'd0) ? tgt_rate - 7'd1 : 7'd0;
					default: rate = (tgt_rate != 7'd127) ? tgt_rate + 7'd1 : 7'd127;
				endcase
				queue_frame(len, flaw, rate);
				rand_bytes += len;
				rand_frames++;
			end
		end
		steady = 1'b0;

		drain();
		$display("Sent %0d bytes; %0d frames rewritten and %0d passed unmodified.",
			n_bytes, n_rewritten, n_plain);
		$display("Used %0d target rate settings, including both ends of the range.",
			n_settings);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
